// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/prot3_pkg.sv
// ----------------------------------------------------------------------------
// prot3_pkg
// shared types, constants and output rounding for the three-axis point rotator
// ----------------------------------------------------------------------------
package prot3_pkg;

    localparam int COORD_W = 16;
    localparam int COEF_W  = 17;
    localparam int OUT_W   = 11;
    localparam int FIN_W   = 23;
    localparam int SHIFT   = 16;
    localparam int BIAS    = 32760;
    localparam int OUT_SH  = 6;

    typedef enum logic [2:0] {
        REG_SIN_FIRST  = 3'd0,
        REG_COS_FIRST  = 3'd1,
        REG_SIN_THIRD  = 3'd2,
        REG_COS_THIRD  = 3'd3,
        REG_SIN_SECOND = 3'd4,
        REG_COS_SECOND = 3'd5
    } reg_idx_t;

    localparam logic signed [COEF_W-1:0] SIN_RESET = 17'sd0;
    localparam logic signed [COEF_W-1:0] COS_RESET = 17'sd65535;

    localparam logic signed [FIN_W-1:0] OUT_MIN = -23'sd1024;
    localparam logic signed [FIN_W-1:0] OUT_MAX = 23'sd1023;
    localparam logic signed [FIN_W-1:0] RND_ADD = 23'sd63;

    // divide by 64 toward zero, then clamp to 11 signed bits
    function automatic logic signed [OUT_W-1:0] finish_coord(input logic signed [FIN_W-1:0] v);
        logic signed [FIN_W-1:0] q;
        q = (v + ((v < 0) ? RND_ADD : 23'sd0)) >>> OUT_SH;
        if (q < OUT_MIN)
        begin
            q = OUT_MIN;
        end
        if (q > OUT_MAX)
        begin
            q = OUT_MAX;
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

// File: hdl/point_rotate_three_axis_q16_core.sv
// ----------------------------------------------------------------------------
// point_rotate_three_axis_q16_core
// pipelined fixed-point rotation of a 3d point through xy, xz and yz planes
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid / in_stall carries px, py, pz and last_point;
//   output channel out_valid / out_stall carries sx, sy, sz and last_out.
//   a request moves at a clock edge with valid high and stall low.
//   sine / cosine registers are written through wr_en, wr_index, wr_data
//   (index 0..5, others ignored); the user must write them only while no
//   request is in flight, and the block itself has no check for this.
// a request taken into stage 1 is on the output once it reaches stage 6.
// throughput: one point per cycle while out_stall is low; six register
//   stages, the last of them the output register, each holding one request.
// each stage advances when it is empty or the stage after it advances, so
//   bubbles close up; a stalled output holds its request and backs the
//   pipeline up until in_stall rises.
// reset clears all valid bits and loads sines with 0 and cosines with 65535.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_rotate_three_axis_q16_core
    import prot3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [2:0]               wr_index,
    input  logic [COEF_W-1:0]        wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    input  logic signed [COORD_W-1:0] pz,
    input  logic                     last_point,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  sx,
    output logic signed [OUT_W-1:0]  sy,
    output logic signed [OUT_W-1:0]  sz,
    output logic                     last_out
);

    // configuration
    logic signed [COEF_W-1:0] sin_first_reg, cos_first_reg;
    logic signed [COEF_W-1:0] sin_second_reg, cos_second_reg;
    logic signed [COEF_W-1:0] sin_third_reg, cos_third_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_first_reg  <= SIN_RESET;
            cos_first_reg  <= COS_RESET;
            sin_second_reg <= SIN_RESET;
            cos_second_reg <= COS_RESET;
            sin_third_reg  <= SIN_RESET;
            cos_third_reg  <= COS_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SIN_FIRST:  sin_first_reg  <= wr_data;
                REG_COS_FIRST:  cos_first_reg  <= wr_data;
                REG_SIN_THIRD:  sin_third_reg  <= wr_data;
                REG_COS_THIRD:  cos_third_reg  <= wr_data;
                REG_SIN_SECOND: sin_second_reg <= wr_data;
                REG_COS_SECOND: cos_second_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // stage control
    logic [6:1] vld_reg;
    logic [6:1] vld_next;
    logic [6:1] adv;

    always_comb
    begin
        adv[6] = !vld_reg[6] || !out_stall;
        adv[5] = !vld_reg[5] || adv[6];
        adv[4] = !vld_reg[4] || adv[5];
        adv[3] = !vld_reg[3] || adv[4];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        vld_next = vld_reg;
        if (adv[1]) vld_next[1] = in_valid;
        if (adv[2]) vld_next[2] = vld_reg[1];
        if (adv[3]) vld_next[3] = vld_reg[2];
        if (adv[4]) vld_next[4] = vld_reg[3];
        if (adv[5]) vld_next[5] = vld_reg[4];
        if (adv[6]) vld_next[6] = vld_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = vld_reg[6];

    // stage 1: xy products
    logic signed [32:0] m1_xc_reg, m1_ys_reg, m1_xs_reg, m1_yc_reg;
    logic signed [COORD_W-1:0] z1_reg;
    logic last1_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            m1_xc_reg <= px * cos_first_reg;
            m1_ys_reg <= py * sin_first_reg;
            m1_xs_reg <= px * sin_first_reg;
            m1_yc_reg <= py * cos_first_reg;
            z1_reg    <= pz;
            last1_reg <= last_point;
        end
    end

    // stage 2: xy sums
    logic signed [33:0] t2_x, t2_y;
    logic signed [17:0] x2_reg, y2_reg;
    logic signed [COORD_W-1:0] z2_reg;
    logic last2_reg;

    assign t2_x = 34'(m1_xc_reg) - 34'(m1_ys_reg);
    assign t2_y = 34'(m1_xs_reg) + 34'(m1_yc_reg);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x2_reg    <= t2_x[33:SHIFT];
            y2_reg    <= t2_y[33:SHIFT];
            z2_reg    <= z1_reg;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: xz products
    logic signed [34:0] m3_xc_reg, m3_zs_reg, m3_xs_reg, m3_zc_reg;
    logic signed [17:0] y3_reg;
    logic last3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            m3_xc_reg <= x2_reg * cos_second_reg;
            m3_zs_reg <= z2_reg * sin_second_reg;
            m3_xs_reg <= x2_reg * sin_second_reg;
            m3_zc_reg <= z2_reg * cos_second_reg;
            y3_reg    <= y2_reg;
            last3_reg <= last2_reg;
        end
    end

    // stage 4: xz sums, x biased
    logic signed [35:0] t4_x, t4_z;
    logic signed [36:0] b4_x;
    logic signed [20:0] x4_reg;
    logic signed [19:0] z4_reg;
    logic signed [17:0] y4_reg;
    logic last4_reg;

    assign t4_x = 36'(m3_xc_reg) - 36'(m3_zs_reg);
    assign t4_z = 36'(m3_xs_reg) + 36'(m3_zc_reg);
    assign b4_x = (t4_x < 0) ? (37'(t4_x) - 37'(BIAS)) : (37'(t4_x) + 37'(BIAS));

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            x4_reg    <= b4_x[36:SHIFT];
            z4_reg    <= t4_z[35:SHIFT];
            y4_reg    <= y3_reg;
            last4_reg <= last3_reg;
        end
    end

    // stage 5: yz products
    logic signed [36:0] m5_yc_reg, m5_zs_reg, m5_ys_reg, m5_zc_reg;
    logic signed [20:0] x5_reg;
    logic last5_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            m5_yc_reg <= y4_reg * cos_third_reg;
            m5_zs_reg <= z4_reg * sin_third_reg;
            m5_ys_reg <= y4_reg * sin_third_reg;
            m5_zc_reg <= z4_reg * cos_third_reg;
            x5_reg    <= x4_reg;
            last5_reg <= last4_reg;
        end
    end

    // stage 6: yz sums, y biased, divide and clamp
    logic signed [37:0] t6_y, t6_z;
    logic signed [38:0] b6_y;
    logic signed [22:0] y6;
    logic signed [21:0] z6;
    logic signed [OUT_W-1:0] sx_reg, sy_reg, sz_reg;
    logic last6_reg;

    assign t6_y = 38'(m5_yc_reg) - 38'(m5_zs_reg);
    assign t6_z = 38'(m5_ys_reg) + 38'(m5_zc_reg);
    assign b6_y = (t6_y < 0) ? (39'(t6_y) - 39'(BIAS)) : (39'(t6_y) + 39'(BIAS));
    assign y6   = b6_y[38:SHIFT];
    assign z6   = t6_z[37:SHIFT];

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            sx_reg    <= finish_coord(FIN_W'(x5_reg));
            sy_reg    <= finish_coord(y6);
            sz_reg    <= finish_coord(FIN_W'(z6));
            last6_reg <= last5_reg;
        end
    end

    assign sx       = sx_reg;
    assign sy       = sy_reg;
    assign sz       = sz_reg;
    assign last_out = last6_reg;

    // checks
    `ASSERT_ALWAYS(a_stall_only_when_blocked, !in_stall || (out_valid && out_stall),
        "input stalled while output free")
    `ASSERT_NEXT(a_request_enters, in_valid && !in_stall, vld_reg[1],
        "accepted request lost at entry")
    `ASSERT_NEXT(a_cfg_cos_first, wr_en && (wr_index == REG_COS_FIRST),
        cos_first_reg == $past(wr_data), "cos_first write not taken")

endmodule
